### src/ulcf_pkg.sv
// Shared types and constants for the mu-law capture FIFO.
// No dependencies; imported by every module of the block.
`default_nettype none

package ulcf_pkg;

  // Ring storage depth in code bytes, and the widths that follow from it
  localparam int DEPTH = 512;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths on the stream ports
  localparam int SMP_W  = 16;
  localparam int CODE_W = 8;
  localparam int FILL_W = 10;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // Request from the input stage to the ring
  typedef struct packed {
    op_e               op;
    logic [CODE_W-1:0] code;
  } ring_req_t;

  // Registered result of one request
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              byte_valid;
    logic              overwrote;
    logic [FILL_W-1:0] fill_count;
  } ring_rsp_t;

endpackage

`default_nettype wire

### src/ulaw_capture_fifo_core.sv
// An accepted request sits in the input register, then its outcome goes
// to the result register. Throughput: one request per cycle unless the
// output stalls; the input register feeds the encoder and ring update.
// A waiting result blocks the input register only while it holds a request.
// Reset clears the read pointer, fill count and valid flags at once; storage
// is not cleared, and no entry is read before it is written.
`default_nettype none

module ulaw_capture_fifo_core
  import ulcf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] adc_sample
  input  wire logic        s_axis_tuser,   // [0] opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // [7:0] code_byte, [8] byte_valid,
                                           // [9] overwrote_oldest,
                                           // [19:10] fill_count, [23:20] zero
);

  logic              in_valid_q;
  op_e               op_q;
  logic [SMP_W-1:0]  sample_q;
  logic              advance;
  logic              out_valid_q;
  logic [CODE_W-1:0] enc_code;
  ring_req_t         req;
  ring_rsp_t         rsp;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q     <= op_e'(s_axis_tuser);
      sample_q <= s_axis_tdata;
    end
  end

  ulcf_encoder u_encoder (
    .sample_i (sample_q),
    .code_o   (enc_code)
  );

  assign req.op   = op_q;
  assign req.code = enc_code;

  ulcf_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, rsp.fill_count, rsp.overwrote, rsp.byte_valid, rsp.code};

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(rsp.byte_valid && rsp.overwrote))
    else $error("pop and overwrite flagged together");

  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rsp.overwrote) |-> (rsp.fill_count == FILL_W'(DEPTH)))
    else $error("overwrite without a full buffer");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(sample_q) && $stable(op_q))
    else $error("stalled request lost");

endmodule

`default_nettype wire

### src/ulcf_encoder.sv
// Piecewise mu-law encoder: offset-binary sample in, 8-bit code out.
// Purely combinational; uses ulcf_pkg for widths.
`default_nettype none

module ulcf_encoder
  import ulcf_pkg::*;
(
  input  wire logic [SMP_W-1:0]  sample_i,
  output logic      [CODE_W-1:0] code_o
);

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sd31608;
  localparam logic signed [SMP_W-1:0] SMP_MIN = -16'sd31616;

  logic signed [SMP_W-1:0] s_raw;
  logic signed [SMP_W-1:0] s_clamp;
  logic                    pos;
  logic [2:0]              seg;
  logic signed [SMP_W-1:0] anchor;
  logic signed [SMP_W-1:0] diff;
  logic [3:0]              shamt;
  logic [SMP_W-1:0]        shifted;

  // Removing the 32768 offset is an MSB flip
  assign s_raw = {~sample_i[SMP_W-1], sample_i[SMP_W-2:0]};

  always_comb begin
    if (s_raw > SMP_MAX) begin
      s_clamp = SMP_MAX;
    end else if (s_raw < SMP_MIN) begin
      s_clamp = SMP_MIN;
    end else begin
      s_clamp = s_raw;
    end
  end

  assign pos = ~s_clamp[SMP_W-1];

  // Segment select; anchor is the segment's top for positives, and the
  // magnitude of the segment's bottom for negatives
  always_comb begin
    if (pos) begin
      if (s_clamp > 16'sd15736) begin
        seg = 3'd0; anchor = 16'sd31608;
      end else if (s_clamp > 16'sd7800) begin
        seg = 3'd1; anchor = 16'sd15736;
      end else if (s_clamp > 16'sd3832) begin
        seg = 3'd2; anchor = 16'sd7800;
      end else if (s_clamp > 16'sd1848) begin
        seg = 3'd3; anchor = 16'sd3832;
      end else if (s_clamp > 16'sd856) begin
        seg = 3'd4; anchor = 16'sd1848;
      end else if (s_clamp > 16'sd360) begin
        seg = 3'd5; anchor = 16'sd856;
      end else if (s_clamp > 16'sd112) begin
        seg = 3'd6; anchor = 16'sd360;
      end else begin
        seg = 3'd7; anchor = 16'sd112;
      end
    end else begin
      if (s_clamp < -16'sd15744) begin
        seg = 3'd0; anchor = 16'sd31616;
      end else if (s_clamp < -16'sd7804) begin
        seg = 3'd1; anchor = 16'sd15744;
      end else if (s_clamp < -16'sd3836) begin
        seg = 3'd2; anchor = 16'sd7804;
      end else if (s_clamp < -16'sd1852) begin
        seg = 3'd3; anchor = 16'sd3836;
      end else if (s_clamp < -16'sd860) begin
        seg = 3'd4; anchor = 16'sd1852;
      end else if (s_clamp < -16'sd364) begin
        seg = 3'd5; anchor = 16'sd860;
      end else if (s_clamp < -16'sd116) begin
        seg = 3'd6; anchor = 16'sd364;
      end else begin
        seg = 3'd7; anchor = 16'sd116;
      end
    end
  end

  // Distance into the segment is never negative and stays below 2^15
  assign diff    = pos ? (anchor - s_clamp) : (s_clamp + anchor);
  assign shamt   = 4'd10 - {1'b0, seg};
  assign shifted = SMP_W'(diff) >> shamt;
  assign code_o  = {pos, seg, shifted[3:0]};

endmodule

`default_nettype wire

### src/ulcf_ring.sv
// Ring buffer of code bytes: pointer/count update, storage, result register.
// Uses ulcf_pkg for depth, widths and the request/response structs.
`default_nettype none

module ulcf_ring
  import ulcf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire ring_req_t req_i,
  output ring_rsp_t      rsp_o
);

  localparam int SUM_W = CNT_W + 1;

  logic [CODE_W-1:0] mem [DEPTH];
  logic [CODE_W-1:0] rdata_q;

  logic [IDX_W-1:0]  oldest_q, oldest_d, oldest_inc;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              full, empty;
  logic [SUM_W-1:0]  pos_sum;
  logic [IDX_W-1:0]  tail_pos;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              valid_d, over_d;
  logic              valid_q, over_q;
  logic [FILL_W-1:0] fill_q;

  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign oldest_inc = (oldest_q == IDX_W'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
  assign pos_sum    = SUM_W'(oldest_q) + SUM_W'(count_q);
  assign tail_pos   = (pos_sum >= SUM_W'(DEPTH)) ? IDX_W'(pos_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(pos_sum);

  always_comb begin
    oldest_d = oldest_q;
    count_d  = count_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = tail_pos;
    valid_d  = 1'b0;
    over_d   = 1'b0;
    case (req_i.op)
      OP_PUSH: begin
        wr_en = en_i;
        if (full) begin
          // new byte lands in the slot of the dropped oldest one
          wr_addr  = oldest_q;
          oldest_d = oldest_inc;
          over_d   = 1'b1;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      OP_POP: begin
        if (!empty) begin
          rd_en    = en_i;
          valid_d  = 1'b1;
          oldest_d = oldest_inc;
          count_d  = count_q - 1'b1;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      count_q  <= '0;
    end else if (en_i) begin
      oldest_q <= oldest_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      valid_q <= valid_d;
      over_q  <= over_d;
      fill_q  <= FILL_W'(count_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= req_i.code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[oldest_q];
    end
  end

  assign rsp_o.code       = valid_q ? rdata_q : '0;
  assign rsp_o.byte_valid = valid_q;
  assign rsp_o.overwrote  = over_q;
  assign rsp_o.fill_count = fill_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("ring count above depth");

  a_oldest_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q <= IDX_W'(DEPTH - 1))
    else $error("oldest index out of range");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for ulaw_capture_fifo_core: encodes pushed samples
// and tracks the ring contents to predict every result. Depends on ulcf_pkg.
`timescale 1ns / 100ps

module tb;
  import ulcf_pkg::*;

  localparam int HOLD_CYCLES = 700;
  localparam int CYCLE_LIMIT = 300000;

  // Tracks the ring contents and the results still owed by the block
  class capture_tracker;
    typedef struct {
      logic [CODE_W-1:0] code;
      logic              valid;
      logic              over;
      logic [FILL_W-1:0] fill;
    } outcome_t;

    logic [CODE_W-1:0] held_bytes[$];
    outcome_t          owed_outcomes[$];
    int                errors = 0;

    // Piecewise mu-law, eight segments per sign
    function automatic logic [7:0] mu_law_code(logic [15:0] raw);
      int s;
      s = int'(raw) - 32768;
      if (s > 31608) s = 31608;
      if (s < -31616) s = -31616;
      if (s >= 0) begin
        if (s > 15736) return 8'(8'h80 + ((31608 - s) >> 10));
        if (s > 7800)  return 8'(8'h90 + ((15736 - s) >> 9));
        if (s > 3832)  return 8'(8'hA0 + ((7800 - s) >> 8));
        if (s > 1848)  return 8'(8'hB0 + ((3832 - s) >> 7));
        if (s > 856)   return 8'(8'hC0 + ((1848 - s) >> 6));
        if (s > 360)   return 8'(8'hD0 + ((856 - s) >> 5));
        if (s > 112)   return 8'(8'hE0 + ((360 - s) >> 4));
        return 8'(8'hF0 + ((112 - s) >> 3));
      end
      if (s < -15744) return 8'((s + 31616) >> 10);
      if (s < -7804)  return 8'(8'h10 + ((s + 15744) >> 9));
      if (s < -3836)  return 8'(8'h20 + ((s + 7804) >> 8));
      if (s < -1852)  return 8'(8'h30 + ((s + 3836) >> 7));
      if (s < -860)   return 8'(8'h40 + ((s + 1852) >> 6));
      if (s < -364)   return 8'(8'h50 + ((s + 860) >> 5));
      if (s < -116)   return 8'(8'h60 + ((s + 364) >> 4));
      return 8'(8'h70 + ((s + 116) >> 3));
    endfunction

    function void note_request(op_e op, logic [15:0] smp);
      outcome_t o;
      o = '{code: '0, valid: 1'b0, over: 1'b0, fill: '0};
      if (op == OP_PUSH) begin
        // full ring: the oldest byte makes room for the new one
        if (held_bytes.size() >= DEPTH) begin
          void'(held_bytes.pop_front());
          o.over = 1'b1;
        end
        held_bytes.push_back(mu_law_code(smp));
      end else if (held_bytes.size() != 0) begin
        o.code  = held_bytes.pop_front();
        o.valid = 1'b1;
      end
      o.fill = FILL_W'(held_bytes.size());
      owed_outcomes.push_back(o);
    endfunction

    function void field_cmp(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [23:0] word);
      outcome_t o;
      if (owed_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, word);
        errors++;
        return;
      end
      o = owed_outcomes.pop_front();
      field_cmp("code_byte", o.code, word[7:0]);
      field_cmp("byte_valid", o.valid, word[8]);
      field_cmp("overwrote_oldest", o.over, word[9]);
      field_cmp("fill_count", o.fill, word[19:10]);
    endfunction

    function int pending();
      return owed_outcomes.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] adc_sample
  logic        s_axis_tuser = 1'b0; // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] code, [8] valid, [9] overwrote, [19:10] fill

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_pending   = 1'b0;
  int cycles         = 0;

  capture_tracker tracker;

  ulaw_capture_fifo_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver side: random stalls, plus a long hold-off on request
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  task automatic send_item(input op_e op, input logic [15:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_request(op, smp);
  endtask

  // Mostly push bursts followed by pops that may run past empty; some noise
  task automatic run_phase(input int n_items);
    int sent;
    int burst;
    int n_pops;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 7) begin
        burst  = $urandom_range(1, 24);
        n_pops = $urandom_range(1, burst + 4);
        repeat (burst) send_item(OP_PUSH, 16'($urandom));
        repeat (n_pops) send_item(OP_POP, 16'($urandom));
        sent += burst + n_pops;
      end else begin
        repeat (8) send_item(op_e'(1'($urandom_range(1))), 16'($urandom));
        sent += 8;
      end
    end
  endtask

  initial begin : main
    logic [15:0] corner_samples[$];
    tracker = new();
    // clamp limits, segment edges on both signs, zero crossing, bit patterns
    corner_samples = '{16'd0, 16'd65535, 16'd32768, 16'd32767, 16'd64376, 16'd64377,
                       16'd1152, 16'd1151, 16'd48504, 16'd48505, 16'd32880, 16'd32881,
                       16'd32652, 16'd32651, 16'd30916, 16'd17024, 16'd17023,
                       16'd34616, 16'hAAAA, 16'h5555};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(OP_POP, 16'hFFFF);  // pop on empty
    foreach (corner_samples[i]) send_item(OP_PUSH, corner_samples[i]);
    repeat (4) send_item(OP_POP, 16'h0000);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      if (p == 0) begin
        // run the ring past full so pushes drop the oldest byte
        repeat (DEPTH + 20) send_item(OP_PUSH, 16'($urandom));
      end
      if (p == 2) begin
        // output held off while pushes keep coming
        hold_pending = 1'b1;
        repeat (60) send_item(OP_PUSH, 16'($urandom));
      end
      run_phase(120);
    end
    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
